FILE: hw/rtl/bihs_pkg.sv
`default_nettype none
package bihs_pkg;

    typedef enum logic [1:0] {
        MODE_EVAL = 2'd0,
        MODE_FLAG = 2'd1,
        MODE_LANE = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    localparam logic [2:0] IMG_ORDINARY = 3'd0;
    localparam logic [2:0] IMG_PENDING  = 3'd1;
    localparam logic [2:0] IMG_CONFIRMED = 3'd2;

    localparam logic [2:0] HS_ORDINARY = 3'd0;
    localparam logic [2:0] HS_AWAITING = 3'd1;
    localparam logic [2:0] HS_SOAKING  = 3'd2;
    localparam logic [2:0] HS_CONFIRM  = 3'd3;
    localparam logic [2:0] HS_CONFIRMED = 3'd4;
    localparam logic [2:0] HS_ROLLBACK = 3'd5;
    localparam logic [2:0] HS_REFUSED  = 3'd6;

    localparam logic [1:0] ACT_NONE     = 2'd0;
    localparam logic [1:0] ACT_CONFIRM  = 2'd1;
    localparam logic [1:0] ACT_ROLLBACK = 2'd2;

    localparam logic [3:0] RSN_ORDINARY     = 4'd0;
    localparam logic [3:0] RSN_CONFIRMED    = 4'd1;
    localparam logic [3:0] RSN_BAD_CONFIG   = 4'd2;
    localparam logic [3:0] RSN_IMG_UNAVAIL  = 4'd3;
    localparam logic [3:0] RSN_AWAIT        = 4'd4;
    localparam logic [3:0] RSN_UNHEALTHY    = 4'd5;
    localparam logic [3:0] RSN_STALE        = 4'd6;
    localparam logic [3:0] RSN_LANE_MISSING = 4'd7;
    localparam logic [3:0] RSN_LANE_STALE   = 4'd8;
    localparam logic [3:0] RSN_LANE_NOPROG  = 4'd9;
    localparam logic [3:0] RSN_SOAKING      = 4'd10;
    localparam logic [3:0] RSN_SOAK_DONE    = 4'd11;
    localparam logic [3:0] RSN_DEADLINE     = 4'd12;
    localparam logic [3:0] RSN_FATAL        = 4'd13;
    localparam logic [3:0] RSN_FATAL_RESET  = 4'd14;
    localparam logic [3:0] RSN_REQUESTED    = 4'd15;

    localparam logic [1:0] CFG_SOAK   = 2'd0;
    localparam logic [1:0] CFG_DEADLINE = 2'd1;
    localparam logic [1:0] CFG_MAXAGE = 2'd2;
    localparam logic [1:0] CFG_MASK   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAGS,
        ST_LANES,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot_index;
        logic        present;
        logic        healthy_or_progressed;
        logic [31:0] obs_stamp_ms;
        logic [31:0] now_ms;
        logic [2:0]  img_state;
        logic        explicit_fatal;
    } t_in;

    typedef struct packed {
        logic [2:0]  health_state;
        logic [1:0]  action;
        logic [3:0]  reason_code;
        logic [31:0] soak_elapsed_ms;
    } t_out;

    // Shared compare unit command and answer.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] limit;
    } t_cmp_req;

    typedef struct packed {
        logic [31:0] diff;
        logic        le;
    } t_cmp_rsp;

endpackage
`default_nettype wire

FILE: hw/rtl/bihs_if.sv
`default_nettype none
interface bihs_in_if;
    logic            valid;
    logic            ready;
    bihs_pkg::t_in   payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bihs_out_if;
    logic            valid;
    logic            ready;
    bihs_pkg::t_out  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bihs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/boot_image_health_supervisor.sv
// Boot image health supervisor.
// Three channels: i_cfg writes registers 0..3 (soak window, pending deadline,
// telemetry maximum age, mandatory lane mask); i_in carries record and
// evaluate items; o_out returns one result per evaluate item.
// A record item is written to its store at the edge that accepts it and gives
// no result; the block is ready again in the next cycle. An evaluate item
// walks the four mandatory flags and then the LANES lanes through one shared
// wrapping subtract/compare unit, one entry a cycle; then it checks the
// configuration, the image state and the freshness of the last observation,
// then the deadline and priority rules, then the soak, stopping at the first
// verdict, and marks the registered result valid in the output state. Input
// is not ready while an item is at work; the next item is taken the cycle
// after its result has been transferred.
// A stalled receiver holds the result in the output register and the block
// waits. Reset (synchronous, active low) clears the config registers, the state
// and the valid bits of both stores, so every flag and lane reads not present.
// Configuration is taken at any time but must change only while idle.
`default_nettype none
module boot_image_health_supervisor #(
    parameter int LANES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bihs_cfg_if.sink   i_cfg,
    bihs_in_if.sink    i_in,
    bihs_out_if.source o_out
);
    localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;

    logic [31:0] r_soak, r_dead, r_age;
    logic [LANES-1:0] r_mask;
    logic r_mask_hi;

    logic [3:0] r_fp, r_fh;
    logic [31:0] r_ft [4];
    logic [LANES-1:0] r_lp, r_lh;
    logic [31:0] r_lt [LANES];

    logic r_pend, r_hasobs, r_cand, r_confreq, r_rbl;
    logic [31:0] r_pstart, r_lastobs, r_hstart;

    bihs_pkg::t_state r_st, n_st;
    bihs_pkg::t_in r_item;
    logic [4:0] r_idx, n_idx;
    logic [3:0] r_rsn, n_rsn;
    logic [1:0] r_ph, n_ph;
    logic r_cfgok;
    bihs_pkg::t_out r_out, n_out;
    logic r_ovalid, n_ovalid;
    logic n_pend, n_hasobs, n_cand, n_confreq, n_rbl;
    logic [31:0] n_pstart, n_lastobs, n_hstart;

    bihs_pkg::t_cmp_req cmp_req;
    bihs_pkg::t_cmp_rsp cmp_rsp;

    bihs_cmp u_cmp (.i_req(cmp_req), .o_rsp(cmp_rsp));

    assign i_cfg.ready = 1'b1;
    assign i_in.ready = (r_st == bihs_pkg::ST_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_out;

    wire in_fire = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soak <= '0; r_dead <= '0; r_age <= '0; r_mask <= '0; r_mask_hi <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                bihs_pkg::CFG_SOAK:     r_soak <= i_cfg.data;
                bihs_pkg::CFG_DEADLINE: r_dead <= i_cfg.data;
                bihs_pkg::CFG_MAXAGE:   r_age <= i_cfg.data;
                bihs_pkg::CFG_MASK: begin
                    r_mask <= i_cfg.data[LANES-1:0];
                    r_mask_hi <= (LANES < 16) ? (|(i_cfg.data[15:0] >> LANES)) : 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Stores: valid bits reset, time stamps without reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fp <= '0; r_fh <= '0; r_lp <= '0; r_lh <= '0;
        end else if (in_fire) begin
            if (i_in.payload.mode == bihs_pkg::MODE_FLAG && i_in.payload.slot_index < 4'd4) begin
                r_fp[i_in.payload.slot_index[1:0]] <= i_in.payload.present;
                r_fh[i_in.payload.slot_index[1:0]] <= i_in.payload.healthy_or_progressed;
            end
            if (i_in.payload.mode == bihs_pkg::MODE_LANE &&
                {1'b0, i_in.payload.slot_index} < 5'(LANES)) begin
                r_lp[i_in.payload.slot_index[LW-1:0]] <= i_in.payload.present;
                r_lh[i_in.payload.slot_index[LW-1:0]] <= i_in.payload.healthy_or_progressed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in.payload.mode == bihs_pkg::MODE_FLAG &&
            i_in.payload.slot_index < 4'd4)
            r_ft[i_in.payload.slot_index[1:0]] <= i_in.payload.obs_stamp_ms;
        if (in_fire && i_in.payload.mode == bihs_pkg::MODE_LANE &&
            {1'b0, i_in.payload.slot_index} < 5'(LANES))
            r_lt[i_in.payload.slot_index[LW-1:0]] <= i_in.payload.obs_stamp_ms;
        if (in_fire) r_item <= i_in.payload;
    end

    localparam logic [31:0] HALF = 32'h8000_0000;

    always_ff @(posedge i_clk) begin
        r_cfgok <= (r_soak != '0) && (r_soak < HALF) && (r_dead > r_soak) &&
                   (r_dead < HALF) && (r_age != '0) && (r_age < HALF) &&
                   (r_mask != '0) && !r_mask_hi;
    end

    logic fresh;
    assign fresh = cmp_rsp.le;

    always_comb begin
        n_st = r_st; n_idx = r_idx; n_rsn = r_rsn; n_ph = r_ph;
        n_out = r_out; n_ovalid = r_ovalid;
        n_pend = r_pend; n_hasobs = r_hasobs; n_cand = r_cand;
        n_confreq = r_confreq; n_rbl = r_rbl;
        n_pstart = r_pstart; n_lastobs = r_lastobs; n_hstart = r_hstart;
        cmp_req.a = r_item.now_ms;
        cmp_req.b = r_ft[r_idx[1:0]];
        cmp_req.limit = r_age;
        if (r_ovalid && o_out.ready) n_ovalid = 1'b0;
        unique case (r_st)
            bihs_pkg::ST_IDLE: begin
                n_idx = '0; n_rsn = '0; n_ph = '0;
                if (in_fire && i_in.payload.mode == bihs_pkg::MODE_EVAL)
                    n_st = bihs_pkg::ST_FLAGS;
            end
            bihs_pkg::ST_FLAGS: begin
                if (r_rsn == 4'd0) begin
                    if (!r_fp[r_idx[1:0]]) n_rsn = bihs_pkg::RSN_AWAIT;
                    else if (!r_fh[r_idx[1:0]]) n_rsn = bihs_pkg::RSN_UNHEALTHY;
                    else if (!fresh) n_rsn = bihs_pkg::RSN_STALE;
                end
                if (r_idx[1:0] == 2'd3) begin
                    n_idx = '0; n_st = bihs_pkg::ST_LANES;
                end else n_idx = r_idx + 5'd1;
            end
            bihs_pkg::ST_LANES: begin
                cmp_req.b = r_lt[r_idx[LW-1:0]];
                if (r_rsn == 4'd0 && r_mask[r_idx[LW-1:0]]) begin
                    if (!r_lp[r_idx[LW-1:0]]) n_rsn = bihs_pkg::RSN_LANE_MISSING;
                    else if (!r_lh[r_idx[LW-1:0]]) n_rsn = bihs_pkg::RSN_LANE_NOPROG;
                    else if (!fresh) n_rsn = bihs_pkg::RSN_LANE_STALE;
                end
                if (r_idx == 5'(LANES - 1)) n_st = bihs_pkg::ST_FINISH;
                else n_idx = r_idx + 5'd1;
            end
            bihs_pkg::ST_FINISH: begin
                // Phase 0: configuration and image state checks, enter pending and check last observation freshness.
                // Phase 1: deadline and priority rules. Phase 2: soak.
                n_out.soak_elapsed_ms = '0;
                n_out.action = bihs_pkg::ACT_NONE;
                unique case (r_ph)
                    2'd0: begin
                        cmp_req.b = r_lastobs;
                        if (!r_cfgok) begin
                            n_out.health_state = bihs_pkg::HS_REFUSED;
                            n_out.reason_code = bihs_pkg::RSN_BAD_CONFIG;
                            n_st = bihs_pkg::ST_OUT;
                        end else if (r_item.img_state != bihs_pkg::IMG_PENDING) begin
                            n_pend = 1'b0; n_hasobs = 1'b0; n_cand = 1'b0;
                            n_confreq = 1'b0; n_rbl = 1'b0;
                            n_st = bihs_pkg::ST_OUT;
                            if (r_item.img_state == bihs_pkg::IMG_ORDINARY) begin
                                n_out.health_state = bihs_pkg::HS_ORDINARY;
                                n_out.reason_code = bihs_pkg::RSN_ORDINARY;
                            end else if (r_item.img_state == bihs_pkg::IMG_CONFIRMED) begin
                                n_out.health_state = bihs_pkg::HS_CONFIRMED;
                                n_out.reason_code = bihs_pkg::RSN_CONFIRMED;
                            end else begin
                                n_out.health_state = bihs_pkg::HS_REFUSED;
                                n_out.reason_code = bihs_pkg::RSN_IMG_UNAVAIL;
                            end
                        end else begin
                            if (!r_pend) begin
                                n_pend = 1'b1; n_pstart = r_item.now_ms;
                                n_cand = 1'b0; n_confreq = 1'b0; n_rbl = 1'b0;
                            end else if (r_hasobs && r_cand && !fresh) n_cand = 1'b0;
                            n_hasobs = 1'b1;
                            n_lastobs = r_item.now_ms;
                            n_ph = 2'd1;
                        end
                    end
                    2'd1: begin
                        cmp_req.b = r_pstart;
                        cmp_req.limit = r_dead - 32'd1;
                        n_st = bihs_pkg::ST_OUT;
                        n_out.health_state = bihs_pkg::HS_ROLLBACK;
                        n_out.action = bihs_pkg::ACT_ROLLBACK;
                        if (r_rbl) begin
                            n_out.action = bihs_pkg::ACT_NONE;
                            n_out.reason_code = bihs_pkg::RSN_REQUESTED;
                        end else if (!cmp_rsp.le) begin
                            n_rbl = 1'b1; n_cand = 1'b0;
                            n_out.reason_code = bihs_pkg::RSN_DEADLINE;
                        end else if (r_item.explicit_fatal) begin
                            n_rbl = 1'b1; n_cand = 1'b0;
                            n_out.reason_code = bihs_pkg::RSN_FATAL;
                        end else if (r_fp[3] && !r_fh[3]) begin
                            n_rbl = 1'b1; n_cand = 1'b0;
                            n_out.reason_code = bihs_pkg::RSN_FATAL_RESET;
                        end else if (r_confreq) begin
                            n_out.action = bihs_pkg::ACT_NONE;
                            n_out.health_state = bihs_pkg::HS_CONFIRM;
                            n_out.reason_code = bihs_pkg::RSN_REQUESTED;
                        end else if (r_rsn != 4'd0) begin
                            n_out.action = bihs_pkg::ACT_NONE;
                            n_cand = 1'b0;
                            n_out.health_state = bihs_pkg::HS_AWAITING;
                            n_out.reason_code = r_rsn;
                        end else begin
                            n_st = bihs_pkg::ST_FINISH;
                            n_ph = 2'd2;
                            if (!r_cand) begin
                                n_cand = 1'b1; n_hstart = r_item.now_ms;
                            end
                        end
                    end
                    default: begin
                        cmp_req.b = r_hstart;
                        cmp_req.limit = r_soak - 32'd1;
                        n_out.soak_elapsed_ms = cmp_rsp.diff;
                        n_st = bihs_pkg::ST_OUT;
                        if (cmp_rsp.le) begin
                            n_out.health_state = bihs_pkg::HS_SOAKING;
                            n_out.reason_code = bihs_pkg::RSN_SOAKING;
                        end else begin
                            n_confreq = 1'b1;
                            n_out.health_state = bihs_pkg::HS_CONFIRM;
                            n_out.action = bihs_pkg::ACT_CONFIRM;
                            n_out.reason_code = bihs_pkg::RSN_SOAK_DONE;
                        end
                    end
                endcase
            end
            bihs_pkg::ST_OUT: begin
                n_ovalid = 1'b1;
                n_st = bihs_pkg::ST_IDLE;
            end
            default: n_st = bihs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= bihs_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_pend <= 1'b0; r_hasobs <= 1'b0; r_cand <= 1'b0;
            r_confreq <= 1'b0; r_rbl <= 1'b0;
            r_pstart <= '0; r_lastobs <= '0; r_hstart <= '0;
        end else begin
            r_st <= n_st;
            r_ovalid <= n_ovalid;
            r_pend <= n_pend; r_hasobs <= n_hasobs; r_cand <= n_cand;
            r_confreq <= n_confreq; r_rbl <= n_rbl;
            r_pstart <= n_pstart; r_lastobs <= n_lastobs; r_hstart <= n_hstart;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_rsn <= n_rsn; r_ph <= n_ph; r_out <= n_out;
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_out.ready |=> r_ovalid && $stable(r_out))
        else $error("result changed while stalled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != bihs_pkg::ST_IDLE |-> !i_in.ready)
        else $error("input ready while busy");
    a_action_rb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_out.action == bihs_pkg::ACT_ROLLBACK |-> r_rbl)
        else $error("rollback issued without latch");
endmodule
`default_nettype wire

FILE: hw/rtl/bihs_cmp.sv
`default_nettype none
module bihs_cmp (
    input  var bihs_pkg::t_cmp_req i_req,
    output bihs_pkg::t_cmp_rsp     o_rsp
);
    // Wrapping difference a - b compared against a limit.
    always_comb begin
        o_rsp.diff = i_req.a - i_req.b;
        o_rsp.le   = (o_rsp.diff <= i_req.limit);
    end
endmodule
`default_nettype wire

FILE: bench/boot_image_health_supervisor_tb.sv
`default_nettype none
module boot_image_health_supervisor_tb;

    localparam int NLANES    = 16;
    localparam int MAX_CYCLE = 400000;
    localparam logic [31:0] HALF = 32'h8000_0000;

    typedef struct packed {
        logic        present;
        logic        healthy;
        logic [31:0] stamp;
    } t_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   item_total = 0;
    int   evals_sent = 0;

    // Scoreboard: holds its own copy of the supervisor state and the queue of
    // verdicts still owed by the block.
    class health_verdict_board;
        logic [31:0] soak_win, deadline, max_age;
        logic [15:0] lane_mask;
        bit          pend_on, have_last, cand_ok, confirm_req, rb_latched;
        logic [31:0] pend_start, last_obs, cand_start;
        t_entry      flags [4];
        t_entry      lanes [NLANES];
        bihs_pkg::t_out pending_verdicts [$];
        int          errors, verdicts_seen;

        function void clear();
            soak_win = '0; deadline = '0; max_age = '0; lane_mask = '0;
            pend_on = 0; have_last = 0; cand_ok = 0; confirm_req = 0; rb_latched = 0;
            pend_start = '0; last_obs = '0; cand_start = '0;
            foreach (flags[i]) flags[i] = '0;
            foreach (lanes[i]) lanes[i] = '0;
            pending_verdicts.delete();
            errors = 0; verdicts_seen = 0;
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
                     cycle_count, what, got, want);
        endtask

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                bihs_pkg::CFG_SOAK:     soak_win  = val;
                bihs_pkg::CFG_DEADLINE: deadline  = val;
                bihs_pkg::CFG_MAXAGE:   max_age   = val;
                bihs_pkg::CFG_MASK:     lane_mask = val[15:0];
                default: ;
            endcase
        endfunction

        function bit fresh(logic [31:0] now, logic [31:0] obs);
            logic [31:0] d;
            d = now - obs;
            return (max_age < HALF) && (d <= max_age);
        endfunction

        function bit elapsed(logic [31:0] now, logic [31:0] since, logic [31:0] ivl);
            logic [31:0] d;
            d = now - since;
            return (ivl < HALF) && (d >= ivl);
        endfunction

        function void push(logic [2:0] st, logic [1:0] act, logic [3:0] rsn,
                           logic [31:0] soak);
            bihs_pkg::t_out v;
            v.health_state = st; v.action = act;
            v.reason_code = rsn; v.soak_elapsed_ms = soak;
            pending_verdicts.push_back(v);
        endfunction

        function void drop_pending();
            pend_on = 0; have_last = 0; cand_ok = 0; confirm_req = 0; rb_latched = 0;
        endfunction

        function logic [3:0] evidence(logic [31:0] now);
            for (int i = 0; i < 4; i++) begin
                if (!flags[i].present) return bihs_pkg::RSN_AWAIT;
                if (!flags[i].healthy) return bihs_pkg::RSN_UNHEALTHY;
                if (!fresh(now, flags[i].stamp)) return bihs_pkg::RSN_STALE;
            end
            for (int i = 0; i < NLANES; i++) begin
                if (!lane_mask[i]) continue;
                if (!lanes[i].present) return bihs_pkg::RSN_LANE_MISSING;
                if (!lanes[i].healthy) return bihs_pkg::RSN_LANE_NOPROG;
                if (!fresh(now, lanes[i].stamp)) return bihs_pkg::RSN_LANE_STALE;
            end
            return bihs_pkg::RSN_ORDINARY;
        endfunction

        function void note_item(bihs_pkg::t_in it);
            t_entry e;
            logic [3:0] rsn;
            bit cfg_good;
            e.present = it.present; e.healthy = it.healthy_or_progressed;
            e.stamp = it.obs_stamp_ms;
            if (it.mode == bihs_pkg::MODE_FLAG) begin
                if (it.slot_index < 4) flags[it.slot_index[1:0]] = e;
                return;
            end
            if (it.mode == bihs_pkg::MODE_LANE) begin
                if (it.slot_index < NLANES) lanes[it.slot_index] = e;
                return;
            end
            if (it.mode != bihs_pkg::MODE_EVAL) return;
            cfg_good = soak_win > 0 && soak_win < HALF && deadline > soak_win &&
                       deadline < HALF && max_age > 0 && max_age < HALF &&
                       lane_mask != '0 && (lane_mask >> NLANES) == '0;
            if (!cfg_good) begin
                push(bihs_pkg::HS_REFUSED, bihs_pkg::ACT_NONE, bihs_pkg::RSN_BAD_CONFIG, '0);
                return;
            end
            if (it.img_state == bihs_pkg::IMG_ORDINARY) begin
                drop_pending();
                push(bihs_pkg::HS_ORDINARY, bihs_pkg::ACT_NONE, bihs_pkg::RSN_ORDINARY, '0);
                return;
            end
            if (it.img_state == bihs_pkg::IMG_CONFIRMED) begin
                drop_pending();
                push(bihs_pkg::HS_CONFIRMED, bihs_pkg::ACT_NONE, bihs_pkg::RSN_CONFIRMED, '0);
                return;
            end
            if (it.img_state != bihs_pkg::IMG_PENDING) begin
                drop_pending();
                push(bihs_pkg::HS_REFUSED, bihs_pkg::ACT_NONE, bihs_pkg::RSN_IMG_UNAVAIL, '0);
                return;
            end
            if (!pend_on) begin
                pend_on = 1; pend_start = it.now_ms; have_last = 1;
                last_obs = it.now_ms; cand_ok = 0; confirm_req = 0; rb_latched = 0;
            end
            if (have_last && cand_ok && !fresh(it.now_ms, last_obs)) cand_ok = 0;
            have_last = 1;
            last_obs = it.now_ms;
            if (rb_latched) begin
                push(bihs_pkg::HS_ROLLBACK, bihs_pkg::ACT_NONE, bihs_pkg::RSN_REQUESTED, '0);
                return;
            end
            if (elapsed(it.now_ms, pend_start, deadline)) begin
                rb_latched = 1; cand_ok = 0;
                push(bihs_pkg::HS_ROLLBACK, bihs_pkg::ACT_ROLLBACK, bihs_pkg::RSN_DEADLINE, '0);
                return;
            end
            if (it.explicit_fatal) begin
                rb_latched = 1; cand_ok = 0;
                push(bihs_pkg::HS_ROLLBACK, bihs_pkg::ACT_ROLLBACK, bihs_pkg::RSN_FATAL, '0);
                return;
            end
            if (flags[3].present && !flags[3].healthy) begin
                rb_latched = 1; cand_ok = 0;
                push(bihs_pkg::HS_ROLLBACK, bihs_pkg::ACT_ROLLBACK,
                     bihs_pkg::RSN_FATAL_RESET, '0);
                return;
            end
            if (confirm_req) begin
                push(bihs_pkg::HS_CONFIRM, bihs_pkg::ACT_NONE, bihs_pkg::RSN_REQUESTED, '0);
                return;
            end
            rsn = evidence(it.now_ms);
            if (rsn != bihs_pkg::RSN_ORDINARY) begin
                cand_ok = 0; push(bihs_pkg::HS_AWAITING, bihs_pkg::ACT_NONE, rsn, '0);
                return;
            end
            if (!cand_ok) begin
                cand_ok = 1; cand_start = it.now_ms;
            end
            if (!elapsed(it.now_ms, cand_start, soak_win)) begin
                push(bihs_pkg::HS_SOAKING, bihs_pkg::ACT_NONE, bihs_pkg::RSN_SOAKING,
                     it.now_ms - cand_start);
                return;
            end
            confirm_req = 1;
            push(bihs_pkg::HS_CONFIRM, bihs_pkg::ACT_CONFIRM, bihs_pkg::RSN_SOAK_DONE,
                 it.now_ms - cand_start);
        endfunction

        task check_verdict(bihs_pkg::t_out got);
            bihs_pkg::t_out exp_v;
            verdicts_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing expected", '0, '0);
                return;
            end
            exp_v = pending_verdicts.pop_front();
            if (got.health_state !== exp_v.health_state)
                report_mismatch("health_state", 32'(got.health_state),
                                32'(exp_v.health_state));
            if (got.action !== exp_v.action)
                report_mismatch("action", 32'(got.action), 32'(exp_v.action));
            if (got.reason_code !== exp_v.reason_code)
                report_mismatch("reason_code", 32'(got.reason_code),
                                32'(exp_v.reason_code));
            if (got.soak_elapsed_ms !== exp_v.soak_elapsed_ms)
                report_mismatch("soak_elapsed_ms", got.soak_elapsed_ms,
                                exp_v.soak_elapsed_ms);
        endtask
    endclass

    health_verdict_board board;

    bihs_cfg_if cfg_bus ();
    bihs_in_if  item_bus ();
    bihs_out_if verdict_bus ();

    boot_image_health_supervisor #(.LANES(NLANES)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (item_bus),
        .o_out   (verdict_bus)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // The receiver stalls at random on the falling edge; results are taken
    // on the rising edge at which a transfer occurs.
    always @(negedge i_clk)
        verdict_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && verdict_bus.valid && verdict_bus.ready)
            board.check_verdict(verdict_bus.payload);

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do @(posedge i_clk); while (!cfg_bus.ready);
        board.set_reg(idx, val);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] soak, logic [31:0] dl, logic [31:0] age,
                              logic [15:0] mask);
        write_reg(bihs_pkg::CFG_SOAK, soak);
        write_reg(bihs_pkg::CFG_DEADLINE, dl);
        write_reg(bihs_pkg::CFG_MAXAGE, age);
        write_reg(bihs_pkg::CFG_MASK, {16'h0, mask});
    endtask

    task automatic send_item(bihs_pkg::t_in it);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        item_bus.valid   <= 1'b1;
        item_bus.payload <= it;
        do @(posedge i_clk); while (!item_bus.ready);
        board.note_item(it);
        item_total++;
        if (it.mode == bihs_pkg::MODE_EVAL) evals_sent++;
        @(negedge i_clk);
        item_bus.valid <= 1'b0;
    endtask

    // Wait for the queue to drain, then for an evaluation's worth of cycles
    // so that a record still being stored has finished.
    task automatic drain();
        int guard;
        guard = 0;
        while (board.pending_verdicts.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    function automatic bihs_pkg::t_in make_record(bihs_pkg::t_mode m, logic [3:0] slot,
                                                  bit pres, bit hl, logic [31:0] obs);
        bihs_pkg::t_in it;
        it = '0;
        it.mode = m; it.slot_index = slot; it.present = pres;
        it.healthy_or_progressed = hl; it.obs_stamp_ms = obs;
        it.now_ms = $urandom; it.img_state = 3'($urandom_range(7));
        it.explicit_fatal = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic bihs_pkg::t_in make_eval(logic [31:0] now, logic [2:0] img, bit fatal);
        bihs_pkg::t_in it;
        it = '0;
        it.mode = bihs_pkg::MODE_EVAL; it.now_ms = now; it.img_state = img;
        it.explicit_fatal = fatal; it.slot_index = 4'($urandom);
        it.present = 1'($urandom_range(1));
        it.healthy_or_progressed = 1'($urandom_range(1));
        it.obs_stamp_ms = $urandom;
        return it;
    endfunction

    // Healthy evidence for all flags and masked lanes, stamped at the given time.
    task automatic feed_evidence(logic [31:0] stamp, logic [15:0] mask);
        for (int i = 0; i < 4; i++)
            send_item(make_record(bihs_pkg::MODE_FLAG, 4'(i), 1'b1, 1'b1, stamp));
        for (int i = 0; i < NLANES; i++)
            if (mask[i])
                send_item(make_record(bihs_pkg::MODE_LANE, 4'(i), 1'b1, 1'b1, stamp));
    endtask

    // A pending-verify episode: evidence, a run of evaluations moving time on,
    // with occasional faults injected and the odd noisy record.
    task automatic episode(logic [15:0] mask, logic [31:0] age);
        logic [31:0] now;
        int steps, pick;
        bihs_pkg::t_in it;
        now = $urandom;
        send_item(make_eval(now, bihs_pkg::IMG_ORDINARY, 1'b0));
        feed_evidence(now, mask);
        steps = $urandom_range(4, 10);
        for (int s = 0; s < steps; s++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                it = make_record(bihs_pkg::MODE_FLAG, 4'($urandom_range(3)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)), now);
                send_item(it);
            end else if (pick < 16) begin
                it = make_record(bihs_pkg::MODE_LANE, 4'($urandom_range(15)),
                                 1'($urandom_range(1)), 1'($urandom_range(1)),
                                 now - $urandom_range(age + 2));
                send_item(it);
            end else if (pick < 22) begin
                it = make_record(bihs_pkg::t_mode'($urandom_range(1, 3)), 4'($urandom),
                                 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
                send_item(it);
            end else if (pick < 30) begin
                feed_evidence(now, mask);
            end
            now = now + $urandom_range(age);
            send_item(make_eval(now, ($urandom_range(99) < 92) ? bihs_pkg::IMG_PENDING
                                : 3'($urandom_range(7)),
                                $urandom_range(99) < 4));
        end
    endtask

    initial begin
        logic [31:0] age;
        logic [15:0] mask;
        board = new();
        board.clear();
        cfg_bus.valid = 0; cfg_bus.index = '0; cfg_bus.data = '0;
        item_bus.valid = 0; item_bus.payload = '0;
        verdict_bus.ready = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusal at reset configuration, then the main verdicts.
        send_item(make_eval(32'h0, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_record(bihs_pkg::MODE_FLAG, 4'd9, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(make_record(bihs_pkg::MODE_NONE, 4'd0, 1'b1, 1'b1, 32'h0));
        drain();
        set_config(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(make_eval(32'hFFFF_FFF0, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'h0000_0010, bihs_pkg::IMG_CONFIRMED, 1'b0));
        send_item(make_eval(32'h0, 3'd5, 1'b0));
        send_item(make_eval(32'h0, 3'd7, 1'b0));
        drain();
        set_config(32'd10, 32'd50, 32'd20, 16'h8001);
        send_item(make_eval(32'hFFFF_FFF8, bihs_pkg::IMG_PENDING, 1'b0));
        feed_evidence(32'hFFFF_FFF8, 16'h8001);
        send_item(make_eval(32'hFFFF_FFFC, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'h0000_0006, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'h0000_0008, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'h0000_0030, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'h0000_0031, bihs_pkg::IMG_PENDING, 1'b1));
        send_item(make_eval(32'h0000_0040, bihs_pkg::IMG_ORDINARY, 1'b0));
        send_item(make_record(bihs_pkg::MODE_FLAG, 4'd3, 1'b1, 1'b0, 32'h40));
        send_item(make_eval(32'h0000_0041, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'h0000_0042, 3'd4, 1'b0));
        send_item(make_eval(32'h0000_0043, bihs_pkg::IMG_PENDING, 1'b1));
        drain();
        set_config(32'd1, 32'd2, 32'd1, 16'h0001);
        send_item(make_eval(32'd0, bihs_pkg::IMG_PENDING, 1'b0));
        send_item(make_eval(32'd5, bihs_pkg::IMG_PENDING, 1'b0));
        drain();

        // Random phases across settings and idling patterns.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            drain();
            age  = (ph == 7) ? 32'h7FFF_FFFF : $urandom_range(5, 400);
            mask = (ph == 3) ? 16'hFFFF : 16'($urandom_range(1, 16'hFFFF));
            if (ph == 5)
                set_config(32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 16'h0);
            else
                set_config($urandom_range(1, 3 * age), $urandom_range(3 * age + 1, 12 * age),
                           age, mask);
            while (item_total < 120 + ph * 80) episode(mask, age);
        end
        drain();

        if (board.pending_verdicts.size() != 0)
            board.report_mismatch("verdicts never returned",
                                  32'(board.pending_verdicts.size()), '0);
        $display("Covered %0d items, %0d evaluations, %0d results checked,",
                 item_total, evals_sent, board.verdicts_seen);
        $display("over several configurations and idling patterns; %0d mismatches.",
                 board.errors);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

FILE: files.f
hw/rtl/bihs_pkg.sv
hw/rtl/bihs_if.sv
hw/rtl/bihs_cmp.sv
hw/rtl/boot_image_health_supervisor.sv
bench/boot_image_health_supervisor_tb.sv
